[src/hpq_pkg.sv]
// Shared types, codes and sizing constants for the max-heap priority queue.
package hpq_pkg;

    localparam int KEY_W            = 32;
    localparam int COUNT_W          = 7;
    localparam int STATUS_W         = 2;
    localparam int DEFAULT_CAPACITY = 64;

    // Request operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [KEY_W-1:0] removed_value;
        logic                    top_valid;
        logic signed [KEY_W-1:0] top_value;
        logic [COUNT_W-1:0]      count;
    } hpq_result_t;

endpackage

[src/hpq_ram.sv]
// Generic single-write, dual-read synchronous RAM with registered read data.
module hpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr0,
    input  logic [AW-1:0]    raddr1,
    output logic [WIDTH-1:0] rdata0,
    output logic [WIDTH-1:0] rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

[src/hpq_engine.sv]
// Heap engine: sift-up / sift-down sequencer over the heap RAM.
module hpq_engine #(
    parameter int CAPACITY = hpq_pkg::DEFAULT_CAPACITY
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic                           op,
    input  logic signed [hpq_pkg::KEY_W-1:0] value,
    output logic                           ready,
    output logic                           res_valid,
    input  logic                           res_ready,
    output hpq_pkg::hpq_result_t           res
);

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int IDX_W = $clog2(CAPACITY + 1);
    localparam int CW    = IDX_W + 1;
    localparam int KW    = hpq_pkg::KEY_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_LAST,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } state_t;

    state_t                             state_reg, state_next;
    logic [IDX_W-1:0]                   idx_reg, idx_next;
    logic [IDX_W-1:0]                   cnt_reg, cnt_next;
    logic signed [KW-1:0]               val_reg, val_next;
    logic [hpq_pkg::STATUS_W-1:0]       status_reg, status_next;
    logic signed [KW-1:0]               removed_reg, removed_next;
    logic signed [KW-1:0]               root_reg;

    logic                               we;
    logic [AW-1:0]                      waddr, raddr0, raddr1;
    logic [KW-1:0]                      wdata, rdata0, rdata1;

    logic [CW-1:0]                      child_l, child_r, cnt_ext, cidx;
    logic                               take_r;
    logic signed [KW-1:0]               cdata;

    assign child_l = CW'(idx_reg) << 1;
    assign child_r = child_l + CW'(1);
    assign cnt_ext = CW'(cnt_reg);
    assign waddr   = AW'(idx_reg - IDX_W'(1));

    // larger child, left wins ties
    assign take_r = (child_r <= cnt_ext) && ($signed(rdata1) > $signed(rdata0));
    assign cdata  = take_r ? $signed(rdata1) : $signed(rdata0);
    assign cidx   = take_r ? child_r : child_l;

    hpq_ram #(
        .WIDTH (KW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk   (aclk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        val_next     = val_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        we           = 1'b0;
        wdata        = val_reg;
        raddr0       = '0;
        raddr1       = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    status_next  = hpq_pkg::ST_DONE;
                    removed_next = '0;
                    if (op == hpq_pkg::OP_INSERT) begin
                        if (cnt_reg == IDX_W'(CAPACITY)) begin
                            status_next = hpq_pkg::ST_FULL;
                            state_next  = S_DONE;
                        end else begin
                            cnt_next   = cnt_reg + IDX_W'(1);
                            idx_next   = cnt_reg + IDX_W'(1);
                            val_next   = value;
                            state_next = S_UP_RD;
                        end
                    end else begin
                        if (cnt_reg == '0) begin
                            status_next = hpq_pkg::ST_EMPTY;
                            state_next  = S_DONE;
                        end else begin
                            removed_next = root_reg;
                            raddr0       = AW'(cnt_reg - IDX_W'(1));
                            cnt_next     = cnt_reg - IDX_W'(1);
                            idx_next     = IDX_W'(1);
                            state_next   = S_DN_LAST;
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (idx_reg == IDX_W'(1)) begin
                    we         = 1'b1;
                    state_next = S_DONE;
                end else begin
                    raddr0     = AW'((idx_reg >> 1) - IDX_W'(1));
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                we = 1'b1;
                if (val_reg > $signed(rdata0)) begin
                    wdata      = rdata0;
                    idx_next   = idx_reg >> 1;
                    state_next = S_UP_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DN_LAST: begin
                val_next   = $signed(rdata0);
                state_next = S_DN_RD;
            end
            S_DN_RD: begin
                if (child_l > cnt_ext) begin
                    we         = 1'b1;
                    state_next = S_DONE;
                end else begin
                    raddr0     = AW'(child_l - CW'(1));
                    raddr1     = AW'(child_l);
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                we = 1'b1;
                if (cdata > val_reg) begin
                    wdata      = cdata;
                    idx_next   = IDX_W'(cidx);
                    state_next = S_DN_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        idx_reg     <= idx_next;
        val_reg     <= val_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
        // root mirror: copy of entry one
        if (we && waddr == '0) begin
            root_reg <= $signed(wdata);
        end
    end

    assign ready             = (state_reg == S_IDLE);
    assign res_valid         = (state_reg == S_DONE);
    assign res.status        = status_reg;
    assign res.removed_value = removed_reg;
    assign res.top_valid     = (cnt_reg != '0);
    assign res.top_value     = (cnt_reg != '0) ? root_reg : '0;
    assign res.count         = hpq_pkg::COUNT_W'(cnt_reg);

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= IDX_W'(CAPACITY))
        else $error("entry count above capacity");

    a_full_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && status_reg == hpq_pkg::ST_FULL)
        |-> cnt_reg == IDX_W'(CAPACITY))
        else $error("insert refused while not full");

    a_empty_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && status_reg == hpq_pkg::ST_EMPTY) |-> cnt_reg == '0)
        else $error("delete refused while not empty");

    a_write_in_sift: assert property (@(posedge aclk) disable iff (!aresetn)
        we |-> (state_reg != S_IDLE && state_reg != S_DONE && state_reg != S_DN_LAST))
        else $error("heap write outside sift");

    a_idx_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UP_RD || state_reg == S_UP_CMP || state_reg == S_DN_RD
         || state_reg == S_DN_CMP) |-> idx_reg != '0)
        else $error("heap index zero during sift");

endmodule

[src/max_heap_priority_queue.sv]
// Top level of the max-heap priority queue: request intake and result register.
//
// Binary max-heap of signed 32-bit keys, CAPACITY entries deep, held in a
// synchronous dual-read RAM. A request with s_op = 0 inserts s_value; s_op = 1
// removes the maximum. Every request yields exactly one result: status (0 done,
// 1 delete refused on empty heap, 2 insert refused on full heap), the removed
// key (zero unless a delete succeeded), the new maximum with its valid flag, and
// the entry count (low 7 bits). One request is in work at a time. A refused
// request goes straight to the result. An insert or delete moves its key at
// most log2(CAPACITY) levels; each level is a RAM read followed by a
// compare/write-back, and a delete first reads the last entry to sink from
// the root. The maximum is mirrored in a register, so reading it costs no
// RAM access. The result register frees the engine as soon as a result is
// parked in it, so the next request is taken while the previous result waits
// on m_ready. No RAM clearing pass is needed after reset: entries beyond the
// count never reach a result.
module max_heap_priority_queue #(
    parameter int CAPACITY = hpq_pkg::DEFAULT_CAPACITY
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic signed [hpq_pkg::KEY_W-1:0]    s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [hpq_pkg::STATUS_W-1:0]        m_status,
    output logic signed [hpq_pkg::KEY_W-1:0]    m_removed_value,
    output logic                                m_top_valid,
    output logic signed [hpq_pkg::KEY_W-1:0]    m_top_value,
    output logic [hpq_pkg::COUNT_W-1:0]         m_count
);

    logic                 eng_ready;
    logic                 eng_res_valid;
    logic                 eng_res_ready;
    hpq_pkg::hpq_result_t eng_res;

    logic                 m_valid_reg, m_valid_next;
    hpq_pkg::hpq_result_t res_reg;

    hpq_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_valid && eng_ready),
        .op        (s_op),
        .value     (s_value),
        .ready     (eng_ready),
        .res_valid (eng_res_valid),
        .res_ready (eng_res_ready),
        .res       (eng_res)
    );

    // Engine may hand over whenever the result slot is empty or draining.
    assign eng_res_ready = !m_valid_reg || m_ready;
    assign s_ready       = eng_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (eng_res_valid && eng_res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (eng_res_valid && eng_res_ready) begin
            res_reg <= eng_res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = res_reg.status;
    assign m_removed_value = res_reg.removed_value;
    assign m_top_valid     = res_reg.top_valid;
    assign m_top_value     = res_reg.top_value;
    assign m_count         = res_reg.count;

endmodule
